@@ rtl/srmq_pkg.sv @@
// Shared constants, field layout and opcodes of the sparse-table range-maximum engine.
`default_nettype none

package srmq_pkg;

   // default configuration
   localparam int DEPTH_DEF      = 1024;
   localparam int LEVELS_DEF     = 11;
   localparam int DATA_WIDTH_DEF = 32;

   // request and response field widths
   localparam int OPCODE_W    = 2;
   localparam int VALUE_W     = 32;
   localparam int POS_FIELD_W = 10;
   localparam int LEN_W       = POS_FIELD_W + 1;
   localparam int MAX_W       = 32;

   // request tdata layout, lowest bit up: value, left, right, zero pad
   localparam int VALUE_LSB  = 0;
   localparam int LEFT_LSB   = VALUE_LSB + VALUE_W;
   localparam int RIGHT_LSB  = LEFT_LSB + POS_FIELD_W;
   localparam int REQ_USED_W = RIGHT_LSB + POS_FIELD_W;
   localparam int REQ_DATA_W = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = MAX_W;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

endpackage

`default_nettype wire

@@ rtl/srmq_table_mem.sv @@
// Window-maximum table memory: one write port and one registered read port.
`default_nettype none

module srmq_table_mem #(
   parameter int DEPTH      = srmq_pkg::DEPTH_DEF,
   parameter int LEVELS     = srmq_pkg::LEVELS_DEF,
   parameter int DATA_WIDTH = srmq_pkg::DATA_WIDTH_DEF,
   parameter int POS_W      = $clog2(DEPTH),
   parameter int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [LVL_W-1:0]      wr_lvl,
   input  wire logic [POS_W-1:0]      wr_pos,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [LVL_W-1:0]      rd_lvl,
   input  wire logic [POS_W-1:0]      rd_pos,
   output logic      [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] table_ff [LEVELS][DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_lvl][wr_pos] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_lvl][rd_pos];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/srmq_max_unit.sv @@
// Shared maximum unit on sign-inverted words, used by both append and query.
`default_nettype none

module srmq_max_unit #(
   parameter int DATA_WIDTH = srmq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic [DATA_WIDTH-1:0] a,
   input  wire logic [DATA_WIDTH-1:0] b,
   output logic      [DATA_WIDTH-1:0] y
);

   // sign bits are stored inverted, so an unsigned compare orders signed values
   assign y = (a > b) ? a : b;

endmodule

`default_nettype wire

@@ rtl/sparse_table_range_max_top.sv @@
// Top level of the sparse-table range-maximum engine: sequencer, ports and checks.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | tuser: opcode; tdata: value, left, right
//   rsp     | out | rsp_tvalid/rsp_tready  | tuser: range_error; tdata: maximum
//
// Append: the accept cycle stores level 0, then one table read per upper level is issued
// back to back on the single read port, and the last window is stored as the loop ends;
// the running maximum chains through the shared max unit. Clear zeroes the element count.
// Query: length decode, two table reads, compare; a range error skips the reads.
// Reset clears state, count, pend_ff and rsp_tvalid; the table holds garbage until written.
// A finished query waits in the output register; the next request is taken meanwhile,
// and a second result stalls the sequencer until rsp_tready frees the register.
`default_nettype none

module sparse_table_range_max_top #(
   parameter int DEPTH      = srmq_pkg::DEPTH_DEF,
   parameter int LEVELS     = srmq_pkg::LEVELS_DEF,
   parameter int DATA_WIDTH = srmq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // bits lowest up: value[31:0], left[41:32], right[51:42], zero pad
   input  wire logic [srmq_pkg::REQ_DATA_W-1:0] req_tdata,
   // bits lowest up: opcode[1:0]
   input  wire logic [srmq_pkg::OPCODE_W-1:0]   req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // bits lowest up: maximum[31:0]
   output logic      [srmq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // bits lowest up: range_error[0]
   output logic      [0:0]                      rsp_tuser
);

   import srmq_pkg::*;

   localparam int POS_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int JW    = $clog2(LEVELS + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int KW    = $clog2(LEN_W);
   localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ALOOP = 3'd1;
   localparam logic [2:0] S_QLOD  = 3'd2;
   localparam logic [2:0] S_QRD1  = 3'd3;
   localparam logic [2:0] S_QRD2  = 3'd4;
   localparam logic [2:0] S_QCMP  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [JW-1:0]          rj_ff, rj_in;
   logic                   pend_ff, pend_in;
   logic [LVL_W-1:0]       pend_lvl_ff, pend_lvl_in;
   logic [POS_W-1:0]       pend_pos_ff, pend_pos_in;
   logic [DATA_WIDTH-1:0]  cur_ff, cur_in;
   logic [POS_FIELD_W-1:0] left_ff, left_in;
   logic [POS_FIELD_W-1:0] right_ff, right_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   err_ff, err_in;
   logic [LVL_W-1:0]       k_ff, k_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MAX_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   mem_we, mem_re;
   logic [LVL_W-1:0]       mem_wlvl, mem_rlvl;
   logic [POS_W-1:0]       mem_wpos, mem_rpos;
   logic [DATA_WIDTH-1:0]  mem_wdata, mem_rdata;
   logic [DATA_WIDTH-1:0]  max_out;

   logic [OPCODE_W-1:0]    req_opcode;
   logic [VALUE_W-1:0]     req_value;
   logic [POS_FIELD_W-1:0] req_left, req_right;
   logic                   req_fire, issue;
   logic [KW-1:0]          k_raw;
   logic [DATA_WIDTH-1:0]  enc_value;

   assign req_opcode = req_tuser;
   assign req_value  = req_tdata[VALUE_LSB +: VALUE_W];
   assign req_left   = req_tdata[LEFT_LSB +: POS_FIELD_W];
   assign req_right  = req_tdata[RIGHT_LSB +: POS_FIELD_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign enc_value  = DATA_WIDTH'(req_value) ^ SIGN_BIT;

   srmq_table_mem #(
      .DEPTH      (DEPTH),
      .LEVELS     (LEVELS),
      .DATA_WIDTH (DATA_WIDTH),
      .POS_W      (POS_W),
      .LVL_W      (LVL_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_lvl  (mem_wlvl),
      .wr_pos  (mem_wpos),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_lvl  (mem_rlvl),
      .rd_pos  (mem_rpos),
      .rd_data (mem_rdata)
   );

   srmq_max_unit #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_max (
      .a (cur_ff),
      .b (mem_rdata),
      .y (max_out)
   );

   // next level read of an append: count_ff already holds pos+1
   assign issue = (32'(rj_ff) < LEVELS) && ((count_ff >> rj_ff) != '0);

   // leading-one detector on the query length
   always_comb begin
      k_raw = '0;
      for (int i = 0; i < LEN_W; i++) begin
         if (len_ff[i]) begin
            k_raw = KW'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rj_in        = rj_ff;
      pend_in      = pend_ff;
      pend_lvl_in  = pend_lvl_ff;
      pend_pos_in  = pend_pos_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      len_in       = len_ff;
      err_in       = err_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      mem_we       = 1'b0;
      mem_wlvl     = '0;
      mem_wpos     = '0;
      mem_wdata    = enc_value;
      mem_re       = 1'b0;
      mem_rlvl     = '0;
      mem_rpos     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_opcode)
                  OP_APPEND: begin
                     if (count_ff != CNT_W'(DEPTH)) begin
                        // level 0 goes in now; upper levels follow in the loop
                        mem_we   = 1'b1;
                        mem_wpos = POS_W'(count_ff);
                        cur_in   = enc_value;
                        count_in = count_ff + 1'b1;
                        rj_in    = JW'(1);
                        pend_in  = 1'b0;
                        state_in = S_ALOOP;
                     end
                  end
                  OP_QUERY: begin
                     left_in  = req_left;
                     right_in = req_right;
                     len_in   = LEN_W'(req_right) - LEN_W'(req_left) + LEN_W'(1);
                     err_in   = (req_left > req_right) ||
                                (CMP_W'(req_right) >= CMP_W'(count_ff));
                     state_in = S_QLOD;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ALOOP: begin
            if (issue) begin
               mem_re      = 1'b1;
               mem_rlvl    = LVL_W'(rj_ff - 1'b1);
               mem_rpos    = POS_W'(count_ff - (CNT_W'(1) << rj_ff));
               pend_lvl_in = LVL_W'(rj_ff);
               pend_pos_in = mem_rpos;
               rj_in       = rj_ff + 1'b1;
            end
            pend_in = issue;
            if (pend_ff) begin
               // fold the left half into the running maximum and store the window
               cur_in    = max_out;
               mem_we    = 1'b1;
               mem_wlvl  = pend_lvl_ff;
               mem_wpos  = pend_pos_ff;
               mem_wdata = max_out;
            end
            // the last window is stored on the way out
            if (!issue) begin
               state_in = S_IDLE;
            end
         end
         S_QLOD: begin
            if (32'(k_raw) > LEVELS - 1) begin
               k_in = LVL_W'(LEVELS - 1);
            end else begin
               k_in = LVL_W'(k_raw);
            end
            state_in = err_ff ? S_QCMP : S_QRD1;
         end
         S_QRD1: begin
            mem_re   = 1'b1;
            mem_rlvl = k_ff;
            mem_rpos = POS_W'(left_ff);
            state_in = S_QRD2;
         end
         S_QRD2: begin
            mem_re   = 1'b1;
            mem_rlvl = k_ff;
            mem_rpos = POS_W'(LEN_W'(right_ff) + LEN_W'(1) - (LEN_W'(1) << k_ff));
            cur_in   = mem_rdata;
            state_in = S_QCMP;
         end
         S_QCMP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_data_in  = err_ff ? '0 : MAX_W'(max_out ^ SIGN_BIT);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rj_ff       <= rj_in;
      pend_lvl_ff <= pend_lvl_in;
      pend_pos_ff <= pend_pos_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      len_ff      <= len_in;
      err_ff      <= err_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count past depth");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_opcode == OP_APPEND && count_ff != CNT_W'(DEPTH))
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not advance the count");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (mem_re && mem_we) |-> (mem_rlvl != mem_wlvl || mem_rpos != mem_wpos))
      else $error("table read and write hit the same entry");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tdata == '0)
      else $error("range error with nonzero maximum");
`endif

endmodule

`default_nettype wire

@@ sim/tb_sparse_table_range_max_top.sv @@
// Self-checking testbench for the sparse-table range-maximum engine: random and directed streams.
`default_nettype none

module tb_sparse_table_range_max_top;
   timeunit 1ns;
   timeprecision 1ps;

   import srmq_pkg::*;

   localparam int TABLE_DEPTH = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int SHOWN_ERRORS = 10;
   localparam int RUN_LEN = 64;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OPCODE_W-1:0]       op;
      logic signed [VALUE_W-1:0] value;
      logic [POS_FIELD_W-1:0]    left;
      logic [POS_FIELD_W-1:0]    right;
   } rmq_request_type;

   typedef struct {
      logic [MAX_W-1:0] maximum;
      logic             range_error;
   } rmq_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OPCODE_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   sparse_table_range_max_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rmq_request_type pending_requests[$];
   rmq_answer_type  expected_answers[$];
   rmq_request_type on_bus;

   // mirror of the stored elements since the last clear
   logic signed [VALUE_W-1:0] stored_vals [TABLE_DEPTH];
   int stored_count = 0;
   int gen_count = 0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_arm = 1'b0;
   int hold_count = 0;
   wire hold_active = hold_arm && (hold_count < HOLD_CYCLES);

   int cycle_count = 0;
   int error_count = 0;
   int results_checked = 0;
   int op_seen [4] = '{default: 0};
   bit table_filled = 1'b0;

   function automatic void apply_request(input rmq_request_type r);
      rmq_answer_type ans;
      logic signed [VALUE_W-1:0] best;
      int i;
      case (r.op)
         OP_APPEND: begin
            if (stored_count < TABLE_DEPTH) begin
               stored_vals[stored_count] = r.value;
               stored_count++;
            end else begin
               table_filled = 1'b1;
            end
         end
         OP_QUERY: begin
            if (r.left > r.right || int'(r.right) >= stored_count) begin
               ans.maximum = '0;
               ans.range_error = 1'b1;
            end else begin
               best = stored_vals[r.left];
               for (i = int'(r.left) + 1; i <= int'(r.right); i++)
                  if (stored_vals[i] > best) best = stored_vals[i];
               ans.maximum = best;
               ans.range_error = 1'b0;
            end
            expected_answers.push_back(ans);
         end
         OP_CLEAR: stored_count = 0;
         default: ;
      endcase
   endfunction

   function automatic void flag_error(input string what);
      error_count++;
      if (error_count <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, what);
   endfunction

   // request driver
   always @(posedge clock) begin
      rmq_request_type nxt;
      logic [REQ_DATA_W-1:0] packed_data;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(on_bus);
            op_seen[on_bus.op]++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_requests.pop_front();
               on_bus = nxt;
               packed_data = '0;
               packed_data[VALUE_LSB +: VALUE_W] = nxt.value;
               packed_data[LEFT_LSB +: POS_FIELD_W] = nxt.left;
               packed_data[RIGHT_LSB +: POS_FIELD_W] = nxt.right;
               req_tdata <= packed_data;
               req_tuser <= nxt.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rmq_answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_answers.size() == 0) begin
               flag_error($sformatf("result with nothing pending: maximum=%0d range_error=%0b",
                                    $signed(rsp_tdata), rsp_tuser[0]));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tdata !== want.maximum || rsp_tuser[0] !== want.range_error)
                  flag_error($sformatf("maximum exp %0d got %0d, range_error exp %0b got %0b",
                                       $signed(want.maximum), $signed(rsp_tdata),
                                       want.range_error, rsp_tuser[0]));
            end
         end
         rsp_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) hold_count <= 0;
      else if (hold_active) hold_count <= hold_count + 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_req(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input int left, input int right);
      rmq_request_type r;
      r.op = op;
      r.value = value;
      r.left = left[POS_FIELD_W-1:0];
      r.right = right[POS_FIELD_W-1:0];
      pending_requests.push_back(r);
      if (op == OP_APPEND && gen_count < TABLE_DEPTH) gen_count++;
      if (op == OP_CLEAR) gen_count = 0;
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) return 32'h7FFF_FFFF;
      if (pick < 8) return 32'h8000_0000;
      // narrow band to force ties
      if (pick < 30) return $urandom_range(8) - 4;
      return $urandom();
   endfunction

   task automatic push_valid_query();
      int r;
      r = $urandom_range(gen_count - 1);
      push_req(OP_QUERY, $urandom(), $urandom_range(r), r);
   endtask

   task automatic queue_random(input int n);
      int i;
      int pick;
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 40 || (pick >= 88 && pick < 93 && gen_count < 32)) begin
            push_req(OP_APPEND, random_value(), $urandom_range(1023), $urandom_range(1023));
         end else if (pick < 80 && gen_count > 0) begin
            push_valid_query();
         end else if (pick < 88) begin
            push_req(OP_QUERY, $urandom(), $urandom_range(1023), $urandom_range(1023));
         end else if (pick < 93) begin
            push_req(OP_CLEAR, $urandom(), $urandom_range(1023), $urandom_range(1023));
         end else if (pick < 96) begin
            push_req(OP_UNUSED, $urandom(), $urandom_range(1023), $urandom_range(1023));
         end else begin
            // near-boundary query: right exactly at the count, one past the last element
            push_req(OP_QUERY, $urandom(), $urandom_range(gen_count), gen_count);
         end
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   task automatic settle();
      while (pending_requests.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   initial begin
      int i;

      // empty table, extremes, ties, inverted and out-of-range bounds
      push_req(OP_QUERY, 0, 0, 0);
      push_req(OP_APPEND, 32'h7FFF_FFFF, 0, 0);
      push_req(OP_APPEND, 32'h8000_0000, 1023, 1023);
      push_req(OP_APPEND, 32'hFFFF_FFFF, 0, 1023);
      push_req(OP_APPEND, 0, 1023, 0);
      push_req(OP_APPEND, 1, 0, 0);
      push_req(OP_QUERY, 0, 0, 0);
      push_req(OP_QUERY, 32'hFFFF_FFFF, 1, 1);
      push_req(OP_QUERY, 0, 0, 4);
      push_req(OP_QUERY, 0, 1, 4);
      push_req(OP_QUERY, 0, 2, 3);
      push_req(OP_QUERY, 0, 3, 1);
      push_req(OP_QUERY, 0, 0, 5);
      push_req(OP_QUERY, 0, 4, 4);
      push_req(OP_QUERY, 0, 1023, 1023);
      push_req(OP_UNUSED, 32'hFFFF_FFFF, 1023, 1023);
      push_req(OP_QUERY, 0, 1, 3);
      push_req(OP_CLEAR, 32'hFFFF_FFFF, 1023, 1023);
      push_req(OP_QUERY, 0, 0, 0);
      push_req(OP_APPEND, 32'h8000_0000, 0, 0);
      push_req(OP_APPEND, 32'h8000_0000, 0, 0);
      push_req(OP_QUERY, 0, 0, 1);
      push_req(OP_CLEAR, 0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      settle();

      // longer run for the upper levels, then wide and inverted queries
      for (i = 0; i < RUN_LEN; i++)
         push_req(OP_APPEND, random_value(), $urandom_range(1023), $urandom_range(1023));
      push_req(OP_QUERY, 0, 0, RUN_LEN - 1);
      push_req(OP_QUERY, 0, RUN_LEN / 2, RUN_LEN - 1);
      push_req(OP_QUERY, 0, RUN_LEN - 1, RUN_LEN - 1);
      push_req(OP_QUERY, 0, 0, RUN_LEN / 2 - 1);
      push_req(OP_QUERY, 0, 1, RUN_LEN - 2);
      push_req(OP_QUERY, 0, 21, 42);
      push_req(OP_QUERY, 0, RUN_LEN - 1, 0);
      for (i = 0; i < 20; i++) push_valid_query();
      push_req(OP_CLEAR, 0, 0, 0);
      settle();

      queue_random(100);
      settle();
      set_idling(70, 0);
      queue_random(100);
      settle();
      set_idling(0, 70);
      queue_random(100);
      settle();
      set_idling(13, 13);
      queue_random(100);
      settle();

      // receiver holds off while queries keep coming
      set_idling(0, 0);
      for (i = 0; i < 16; i++) push_req(OP_APPEND, random_value(), 0, 0);
      settle();
      @(posedge clock);
      hold_arm <= 1'b1;
      for (i = 0; i < 40; i++) push_valid_query();
      settle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d appends, %0d queries, %0d clears, %0d unused codes; %0d results checked.",
               op_seen[OP_APPEND], op_seen[OP_QUERY], op_seen[OP_CLEAR], op_seen[OP_UNUSED],
               results_checked);
      $display("Table filled past capacity: %0s; mismatches: %0d.", table_filled ? "yes" : "no",
               error_count);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
rtl/srmq_pkg.sv
rtl/srmq_table_mem.sv
rtl/srmq_max_unit.sv
rtl/sparse_table_range_max_top.sv
sim/tb_sparse_table_range_max_top.sv
